FILE: rtl/core/rtmt_pkg.sv
// ----------------------------------------------------------------------------
// rtmt_pkg
// Shared types and constants of the ratio test match table.
// ----------------------------------------------------------------------------
package rtmt_pkg;

    localparam int unsigned CNT_W      = 7;
    localparam int unsigned LIM_W      = 17;
    localparam logic [6:0]  NO_SLOT    = 7'd127;
    localparam logic [31:0] START_DIST = 32'd1000000;

    localparam logic REG_RATIO  = 1'b0;
    localparam logic REG_REFCNT = 1'b1;

    typedef enum logic [1:0] {
        CMD_START   = 2'd0,
        CMD_PRELOAD = 2'd1,
        CMD_CAND    = 2'd2,
        CMD_FINISH  = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_NEW        = 3'd0,
        ST_REPLACED   = 3'd1,
        ST_RATIO_FAIL = 3'd2,
        ST_NOT_BETTER = 3'd3,
        ST_FULL       = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_CAND,
        BK_MAX_RD,
        BK_MAX_CMP,
        BK_EM_RD,
        BK_EM_START,
        BK_EM_WAIT
    } bk_state_t;

    // One classified command waiting for the back end.
    typedef struct packed {
        cmd_t        cmd;
        logic [15:0] query;
        logic [9:0]  ref_idx;
        logic [31:0] near_dist;
        logic        ratio_ok;
        logic        in_range;
    } entry_t;

    typedef struct packed {
        logic        kind;
        status_t     status;
        logic [5:0]  slot;
        logic [15:0] match_query;
        logic [9:0]  match_ref;
        logic [31:0] confidence;
        logic [16:0] norm_confidence;
        logic        last;
    } result_t;

    typedef struct packed {
        logic             init_clear;
        logic [CNT_W-1:0] slot_count;
    } bk_stat_t;

endpackage

FILE: rtl/core/rtmt_front.sv
// ----------------------------------------------------------------------------
// rtmt_front
// Accepts input beats, applies the ratio test and the reference range check,
// and holds the classified commands in a two-entry queue.
// ----------------------------------------------------------------------------
module rtmt_front
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [1:0]                     in_cmd,
    input  logic [15:0]                    in_query,
    input  logic [9:0]                     in_ref,
    input  logic [31:0]                    in_near,
    input  logic [31:0]                    in_second,
    input  logic [16:0]                    ratio_threshold,
    input  logic [rtmt_pkg::LIM_W-1:0]     ref_limit,
    input  logic                           hold,
    output logic                           head_valid,
    output rtmt_pkg::entry_t               head,
    input  logic                           pop
);

    rtmt_pkg::entry_t q_reg [2];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       cnt_reg, cnt_next;
    logic             push;
    logic [47:0]      lhs;
    logic [48:0]      rhs;
    rtmt_pkg::entry_t new_entry;

    assign lhs = {in_near, 16'd0};
    assign rhs = ratio_threshold * in_second;

    always_comb
    begin
        new_entry.cmd       = rtmt_pkg::cmd_t'(in_cmd);
        new_entry.query     = in_query;
        new_entry.ref_idx   = in_ref;
        new_entry.near_dist = in_near;
        new_entry.ratio_ok  = {1'b0, lhs} < rhs;
        new_entry.in_range  = rtmt_pkg::LIM_W'(in_ref) < ref_limit;
    end

    assign in_ready   = (cnt_reg != 2'd2) && !hold;
    assign push       = in_valid && in_ready;
    assign head_valid = cnt_reg != 2'd0;
    assign head       = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        cnt_next    = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= new_entry;
        end
    end

endmodule

FILE: rtl/core/rtmt_div.sv
// ----------------------------------------------------------------------------
// rtmt_div
// Restoring divider giving (num * 65536) / den as a 17-bit quotient, for
// num no larger than den. One quotient bit per cycle.
// ----------------------------------------------------------------------------
module rtmt_div
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] num,
    input  logic [31:0] den,
    output logic        done,
    output logic [16:0] quot
);

    logic [32:0] rem_reg, rem_next;
    logic [31:0] den_reg, den_next;
    logic [16:0] quot_reg, quot_next;
    logic [4:0]  step_reg, step_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic        ge;
    logic [32:0] diff;

    assign ge   = rem_reg >= {1'b0, den_reg};
    assign diff = rem_reg - {1'b0, den_reg};

    always_comb
    begin
        rem_next  = rem_reg;
        den_next  = den_reg;
        quot_next = quot_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = {1'b0, num};
            den_next  = den;
            quot_next = 17'd0;
            step_next = 5'd16;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next  = ge ? {diff[31:0], 1'b0} : {rem_reg[31:0], 1'b0};
            quot_next = {quot_reg[15:0], ge};
            step_next = step_reg - 5'd1;
            if (step_reg == 5'd0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= 5'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        quot_reg <= quot_next;
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

FILE: rtl/core/rtmt_back.sv
// ----------------------------------------------------------------------------
// rtmt_back
// Carries out queued commands against the per-reference table and the match
// slots, runs the clearing pass and the normalised emission on finish.
// ----------------------------------------------------------------------------
module rtmt_back
#(
    parameter int unsigned REF_POINTS  = 1024,
    parameter int unsigned MAX_MATCHES = 64
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                head_valid,
    input  rtmt_pkg::entry_t    head,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_ready,
    output rtmt_pkg::result_t   out_data,
    output rtmt_pkg::bk_stat_t  stat
);

    localparam int unsigned RW  = $clog2(REF_POINTS);
    localparam int unsigned SLW = (MAX_MATCHES > 1) ? $clog2(MAX_MATCHES) : 1;
    localparam int unsigned CW  = rtmt_pkg::CNT_W;

    // Per reference point: {slot marker, best distance}.
    logic [38:0] ref_mem [REF_POINTS];
    logic [38:0] ref_rd_reg;
    logic        ref_we;
    logic [RW-1:0] ref_waddr, ref_raddr;
    logic [38:0] ref_wdata;

    // Per slot: {query, reference, confidence}.
    logic [57:0] slot_mem [MAX_MATCHES];
    logic [57:0] slot_rd_reg;
    logic        slot_we;
    logic [SLW-1:0] slot_waddr, slot_raddr;
    logic [57:0] slot_wdata;

    rtmt_pkg::bk_state_t state_reg, state_next;
    logic [RW-1:0]       clr_idx_reg, clr_idx_next;
    logic [SLW-1:0]      idx_reg, idx_next;
    logic [CW-1:0]       count_reg, count_next;
    logic                init_reg, init_next;
    rtmt_pkg::entry_t    cur_reg, cur_next;
    logic [31:0]         maxc_reg, maxc_next;
    logic                out_valid_reg, out_valid_next;
    rtmt_pkg::result_t   out_reg, out_next;

    // Divider completion is a pulse; hold it until the next division is started.
    logic                div_seen_reg, div_seen_next;

    logic        out_free;
    logic        div_start, div_done;
    logic [16:0] div_quot;
    logic [6:0]  marker;
    logic [31:0] best;
    logic        last_idx;

    rtmt_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (slot_rd_reg[31:0]),
        .den   (maxc_reg),
        .done  (div_done),
        .quot  (div_quot)
    );

    assign out_free = !out_valid_reg || out_ready;
    assign marker   = ref_rd_reg[38:32];
    assign best     = ref_rd_reg[31:0];
    assign last_idx = CW'(idx_reg) == (count_reg - CW'(1));

    always_comb
    begin
        state_next     = state_reg;
        clr_idx_next   = clr_idx_reg;
        idx_next       = idx_reg;
        count_next     = count_reg;
        init_next      = init_reg;
        cur_next       = cur_reg;
        maxc_next      = maxc_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_next       = out_reg;
        pop            = 1'b0;
        ref_we         = 1'b0;
        ref_waddr      = RW'(head.ref_idx);
        ref_wdata      = {count_reg, head.near_dist};
        ref_raddr      = RW'(head.ref_idx);
        slot_we        = 1'b0;
        slot_waddr     = SLW'(count_reg);
        slot_wdata     = {head.query, head.ref_idx, head.near_dist};
        slot_raddr     = idx_reg;
        div_start      = 1'b0;

        unique case (state_reg)
            rtmt_pkg::BK_CLEAR:
            begin
                ref_we       = 1'b1;
                ref_waddr    = clr_idx_reg;
                ref_wdata    = {rtmt_pkg::NO_SLOT, rtmt_pkg::START_DIST};
                clr_idx_next = clr_idx_reg + RW'(1);
                if (clr_idx_reg == RW'(REF_POINTS - 1))
                begin
                    init_next  = 1'b0;
                    state_next = rtmt_pkg::BK_IDLE;
                end
            end

            rtmt_pkg::BK_IDLE:
            begin
                if (head_valid)
                begin
                    unique case (head.cmd)
                        rtmt_pkg::CMD_START:
                        begin
                            pop          = 1'b1;
                            count_next   = '0;
                            clr_idx_next = '0;
                            state_next   = rtmt_pkg::BK_CLEAR;
                        end
                        rtmt_pkg::CMD_PRELOAD:
                        begin
                            pop = 1'b1;
                            if (head.in_range && count_reg < CW'(MAX_MATCHES))
                            begin
                                ref_we     = 1'b1;
                                slot_we    = 1'b1;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        rtmt_pkg::CMD_CAND:
                        begin
                            if (out_free)
                            begin
                                pop      = 1'b1;
                                cur_next = head;
                                out_next.kind            = 1'b0;
                                out_next.slot            = 6'd0;
                                out_next.match_query     = head.query;
                                out_next.match_ref       = head.ref_idx;
                                out_next.confidence      = head.near_dist;
                                out_next.norm_confidence = 17'd0;
                                out_next.last            = 1'b0;
                                if (!head.ratio_ok)
                                begin
                                    out_next.status = rtmt_pkg::ST_RATIO_FAIL;
                                    out_valid_next  = 1'b1;
                                end
                                else if (!head.in_range)
                                begin
                                    out_next.status = rtmt_pkg::ST_NOT_BETTER;
                                    out_valid_next  = 1'b1;
                                end
                                else
                                begin
                                    state_next = rtmt_pkg::BK_CAND;
                                end
                            end
                        end
                        rtmt_pkg::CMD_FINISH:
                        begin
                            pop = 1'b1;
                            if (count_reg != '0)
                            begin
                                idx_next   = '0;
                                maxc_next  = 32'd0;
                                state_next = rtmt_pkg::BK_MAX_RD;
                            end
                        end
                        default:
                        begin
                            pop = 1'b0;
                        end
                    endcase
                end
            end

            rtmt_pkg::BK_CAND:
            begin
                // Read data of the reference entry is valid here.
                ref_waddr      = RW'(cur_reg.ref_idx);
                slot_wdata     = {cur_reg.query, cur_reg.ref_idx, cur_reg.near_dist};
                out_valid_next = 1'b1;
                state_next     = rtmt_pkg::BK_IDLE;
                if (!(best > cur_reg.near_dist))
                begin
                    out_next.status = rtmt_pkg::ST_NOT_BETTER;
                end
                else if (marker != rtmt_pkg::NO_SLOT)
                begin
                    ref_we          = 1'b1;
                    ref_wdata       = {marker, cur_reg.near_dist};
                    slot_we         = 1'b1;
                    slot_waddr      = SLW'(marker);
                    out_next.status = rtmt_pkg::ST_REPLACED;
                    out_next.slot   = 6'(marker);
                end
                else if (count_reg >= CW'(MAX_MATCHES))
                begin
                    out_next.status = rtmt_pkg::ST_FULL;
                end
                else
                begin
                    ref_we          = 1'b1;
                    ref_wdata       = {count_reg, cur_reg.near_dist};
                    slot_we         = 1'b1;
                    count_next      = count_reg + CW'(1);
                    out_next.status = rtmt_pkg::ST_NEW;
                    out_next.slot   = 6'(count_reg);
                end
            end

            rtmt_pkg::BK_MAX_RD:
            begin
                state_next = rtmt_pkg::BK_MAX_CMP;
            end

            rtmt_pkg::BK_MAX_CMP:
            begin
                if (slot_rd_reg[31:0] > maxc_reg)
                begin
                    maxc_next = slot_rd_reg[31:0];
                end
                if (last_idx)
                begin
                    idx_next   = '0;
                    state_next = rtmt_pkg::BK_EM_RD;
                end
                else
                begin
                    idx_next   = idx_reg + SLW'(1);
                    state_next = rtmt_pkg::BK_MAX_RD;
                end
            end

            rtmt_pkg::BK_EM_RD:
            begin
                state_next = rtmt_pkg::BK_EM_START;
            end

            rtmt_pkg::BK_EM_START:
            begin
                div_start  = 1'b1;
                state_next = rtmt_pkg::BK_EM_WAIT;
            end

            rtmt_pkg::BK_EM_WAIT:
            begin
                // The quotient stays put after done, so waiting on the output is safe.
                if (div_seen_reg && out_free)
                begin
                    out_valid_next           = 1'b1;
                    out_next.kind            = 1'b1;
                    out_next.status          = rtmt_pkg::ST_NEW;
                    out_next.slot            = 6'(idx_reg);
                    out_next.match_query     = slot_rd_reg[57:42];
                    out_next.match_ref       = slot_rd_reg[41:32];
                    out_next.confidence      = slot_rd_reg[31:0];
                    out_next.norm_confidence = (maxc_reg == 32'd0) ? 17'd0 : div_quot;
                    out_next.last            = last_idx;
                    if (last_idx)
                    begin
                        state_next = rtmt_pkg::BK_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + SLW'(1);
                        state_next = rtmt_pkg::BK_EM_RD;
                    end
                end
            end

            default:
            begin
                state_next = rtmt_pkg::BK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        div_seen_next = div_seen_reg;
        if (div_start)
        begin
            div_seen_next = 1'b0;
        end
        else if (div_done)
        begin
            div_seen_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rtmt_pkg::BK_CLEAR;
            clr_idx_reg   <= '0;
            idx_reg       <= '0;
            count_reg     <= '0;
            init_reg      <= 1'b1;
            out_valid_reg <= 1'b0;
            div_seen_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_idx_reg   <= clr_idx_next;
            idx_reg       <= idx_next;
            count_reg     <= count_next;
            init_reg      <= init_next;
            out_valid_reg <= out_valid_next;
            div_seen_reg  <= div_seen_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg  <= cur_next;
        maxc_reg <= maxc_next;
        out_reg  <= out_next;
    end

    always_ff @(posedge clk)
    begin
        if (ref_we)
        begin
            ref_mem[ref_waddr] <= ref_wdata;
        end
        ref_rd_reg <= ref_mem[ref_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (slot_we)
        begin
            slot_mem[slot_waddr] <= slot_wdata;
        end
        slot_rd_reg <= slot_mem[slot_raddr];
    end

    assign out_valid       = out_valid_reg;
    assign out_data        = out_reg;
    assign stat.init_clear = init_reg;
    assign stat.slot_count = count_reg;

endmodule

FILE: rtl/core/ratio_test_match_table.sv
// ----------------------------------------------------------------------------
// ratio_test_match_table
// Ratio test filter for feature matches with a per-reference match table.
// ----------------------------------------------------------------------------
// A candidate does one read-modify-write of the reference table port, over the
// idle and candidate states; one that fails the ratio or range check, and a
// preload, are handled in the idle state alone. Start clears REF_POINTS
// reference entries at one per cycle. Finish with n slots sweeps them for the
// maximum confidence, then emits one beat per slot, each waiting on the
// bit-serial divider. After reset a clearing pass runs with input not ready.
module ratio_test_match_table
#(
    parameter int unsigned REF_POINTS  = 1024,
    parameter int unsigned MAX_MATCHES = 64
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // query_index, ref_index, nearest_dist, second_dist
    input  logic [95:0]  s_axis_tdata,
    // command
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // status, slot, match_query, match_ref, confidence, norm_confidence
    output logic [87:0]  m_axis_tdata,
    // kind
    output logic [0:0]   m_axis_tuser,
    output logic         m_axis_tlast,
    input  logic         cfg_we,
    input  logic         cfg_index,
    input  logic [16:0]  cfg_data
);

    logic [16:0]                        ratio_reg;
    logic [10:0]                        refcnt_reg;
    logic [rtmt_pkg::LIM_W-1:0]         ref_limit;
    logic                               head_valid;
    logic                               pop;
    rtmt_pkg::entry_t                   head;
    rtmt_pkg::result_t                  res;
    rtmt_pkg::bk_stat_t                 stat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ratio_reg  <= 17'd52429;
            refcnt_reg <= 11'd1024;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                rtmt_pkg::REG_RATIO:  ratio_reg  <= cfg_data;
                rtmt_pkg::REG_REFCNT: refcnt_reg <= cfg_data[10:0];
                default:              ratio_reg  <= ratio_reg;
            endcase
        end
    end

    assign ref_limit = (rtmt_pkg::LIM_W'(refcnt_reg) < rtmt_pkg::LIM_W'(REF_POINTS))
                       ? rtmt_pkg::LIM_W'(refcnt_reg) : rtmt_pkg::LIM_W'(REF_POINTS);

    rtmt_front u_front
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (s_axis_tvalid),
        .in_ready        (s_axis_tready),
        .in_cmd          (s_axis_tuser),
        .in_query        (s_axis_tdata[15:0]),
        .in_ref          (s_axis_tdata[25:16]),
        .in_near         (s_axis_tdata[57:26]),
        .in_second       (s_axis_tdata[89:58]),
        .ratio_threshold (ratio_reg),
        .ref_limit       (ref_limit),
        .hold            (stat.init_clear),
        .head_valid      (head_valid),
        .head            (head),
        .pop             (pop)
    );

    rtmt_back
    #(
        .REF_POINTS  (REF_POINTS),
        .MAX_MATCHES (MAX_MATCHES)
    )
    u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_data   (res),
        .stat       (stat)
    );

    assign m_axis_tdata = {4'd0, res.norm_confidence, res.confidence, res.match_ref,
                           res.match_query, res.slot, res.status};
    assign m_axis_tuser = res.kind;
    assign m_axis_tlast = res.last;

`ifndef SYNTHESIS
    a_no_out_in_init : assert property (@(posedge clk) disable iff (!rst_n)
        stat.init_clear |-> !m_axis_tvalid)
        else $error("result beat during the reset clearing pass");

    a_no_in_in_init : assert property (@(posedge clk) disable iff (!rst_n)
        stat.init_clear |-> !s_axis_tready)
        else $error("input ready during the reset clearing pass");

    a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
        stat.slot_count <= rtmt_pkg::CNT_W'(MAX_MATCHES))
        else $error("slot count above table size");
`endif

endmodule
